// ===== sv/pbe_pkg.sv =====
package pbe_pkg;

  localparam int MAX_KEYS  = 16;
  localparam int IDX_W     = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int TIME_W    = 16;
  localparam int VAL_W     = 16;
  localparam int DEV_W     = 17;
  localparam int TQ_W      = 17;
  localparam int COEF_W    = 26;
  localparam int U1_W      = 44;
  localparam int M2_W      = 62;
  localparam int U3_W      = 64;
  localparam int OUT_W     = 20;
  localparam int ERR_W     = 2;
  localparam int DIV_STEPS = TQ_W;

  localparam logic [CNT_W-1:0] KEY_COUNT_RESET = CNT_W'(2);

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_RANGE     = 2'd1,
    ERR_ORDER     = 2'd2,
    ERR_BAD_INDEX = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_COEF,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0]        ktime;
    logic signed [VAL_W-1:0]  kvalue;
    logic [DEV_W-1:0]         kdev;
  } entry_t;

endpackage

// ===== sv/piecewise_cubic_bezier_eval_core.sv =====
// Channel  Handshake             Payload
// input    in_valid / in_stall   mode, index, key_time, key_value, variation_ratio, query_time
// output   out_valid / out_stall curve_value, error_code
// config   cfg_valid / cfg_ready cfg_data (key_count)
//
// A load word shows its result in the cycle after acceptance. A query word runs
// the memory scan over the n keypoints in use (one read port, one entry a cycle),
// then the restoring divider, the coefficients, three dependent multiplies and
// the rounding before its result shows; a query that fails its order or range
// check goes from the scan straight to its result.
// Reset (rst, synchronous) clears control state and sets key_count to two; the
// keypoint memory is not cleared. The block takes one word at a time and holds
// in_stall high during reset, while a word is in progress or while a result
// waits under out_stall.
module piecewise_cubic_bezier_eval_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [pbe_pkg::IDX_W-1:0]         index,
  input  logic [pbe_pkg::TIME_W-1:0]        key_time,
  input  logic signed [pbe_pkg::VAL_W-1:0]  key_value,
  input  logic [15:0]                       variation_ratio,
  input  logic [pbe_pkg::TIME_W-1:0]        query_time,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pbe_pkg::OUT_W-1:0]  curve_value,
  output logic [pbe_pkg::ERR_W-1:0]         error_code,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbe_pkg::CNT_W-1:0]         cfg_data
);
  import pbe_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0] key_count;
  logic [CNT_W-1:0] n_used;
  logic [IDX_W-1:0] last_idx;

  // Keypoint memory: one write port, one registered read port.
  entry_t           mem [MAX_KEYS];
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_q;
  logic             wr_en;
  entry_t           wr_entry;

  logic [IDX_W-1:0]  rd_idx;
  logic [TIME_W-1:0] q;
  entry_t            prev, lo, hi;
  logic              bad, found;

  logic [TIME_W-1:0] rem;
  logic [TQ_W-1:0]   quo;
  logic [4:0]        dcnt;

  logic signed [COEF_W-1:0] ca, cb, cc;
  logic signed [VAL_W-1:0]  p0;
  logic signed [U1_W-1:0]   u1, u2;
  logic signed [U3_W-1:0]   u3;

  logic [ERR_W-1:0]         res_err;

  logic                     accept;
  logic                     out_free;
  logic                     out_load;

  // Load path arithmetic.
  logic [VAL_W:0]           mag;
  logic [32:0]              dev_prod;
  logic [18:0]              dev_round;

  // Scan, divide and evaluation wires.
  logic                     scan_bad, scan_found;
  logic [TIME_W:0]          trial;
  logic [TIME_W-1:0]        seg_len;
  logic                     take;
  logic signed [COEF_W-1:0] dv, dl, dh, b_w, a_w;
  logic signed [TQ_W:0]     tqs;
  logic signed [U1_W-1:0]   m1;
  logic signed [M2_W-1:0]   m2;
  logic signed [M2_W-1:0]   m3;
  logic signed [U3_W-1:0]   rsum;
  logic signed [31:0]       rshift;
  logic signed [OUT_W-1:0]  sat;

  assign cfg_ready = !rst;
  assign n_used    = (key_count < CNT_W'(2)) ? CNT_W'(2) :
                     (key_count > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : key_count;
  assign last_idx  = IDX_W'(n_used - CNT_W'(1));
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = rst || (state != ST_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  // A result word is presented from a load in idle or from the final state.
  assign out_load  = ((state == ST_IDLE) && accept && (mode == MODE_LOAD)) ||
                     ((state == ST_FIN) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= KEY_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      key_count <= cfg_data;
    end
  end

  // Deviation: ratio times magnitude, rounded half up, kept to 17 bits.
  always_comb begin
    mag       = key_value[VAL_W-1] ? (VAL_W+1)'(-$signed({key_value[VAL_W-1], key_value}))
                                   : {1'b0, key_value};
    dev_prod  = 33'(variation_ratio) * 33'(mag);
    dev_round = 19'((dev_prod + 33'd8192) >> 14);
    wr_entry  = '{ktime: key_time, kvalue: key_value, kdev: dev_round[DEV_W-1:0]};
    wr_en     = accept && (mode == MODE_LOAD) && ({1'b0, index} < n_used);
  end

  always_comb begin
    rd_addr = (state == ST_SCAN) ? rd_idx + IDX_W'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[index] <= wr_entry;
    end
    rd_q <= mem[rd_addr];
  end

  // Scan step: rd_q holds entry rd_idx, prev holds entry rd_idx - 1.
  always_comb begin
    scan_bad   = bad;
    scan_found = found;
    if (rd_idx != '0) begin
      if (rd_q.ktime <= prev.ktime) begin
        scan_bad = 1'b1;
      end
      if (!found && prev.ktime <= q && q <= rd_q.ktime) begin
        scan_found = 1'b1;
      end
    end
  end

  // Restoring division of (q - t_lo) * 2^16 by the segment length.
  always_comb begin
    seg_len = hi.ktime - lo.ktime;
    trial   = (dcnt == '0) ? {1'b0, q - lo.ktime} : {rem, 1'b0};
    take    = trial >= {1'b0, seg_len};
  end

  // Coefficients: c = 3 d_lo, b = 3 (v_hi - v_lo - d_hi) - 6 d_lo, a = dv - c - b.
  always_comb begin
    dv  = COEF_W'(hi.kvalue) - COEF_W'(lo.kvalue);
    dl  = $signed(COEF_W'(lo.kdev));
    dh  = $signed(COEF_W'(hi.kdev));
    b_w = COEF_W'(3) * (dv - dh) - COEF_W'(6) * dl;
    a_w = dv - COEF_W'(3) * dl - b_w;
  end

  always_comb begin
    tqs    = $signed({1'b0, quo});
    m1     = U1_W'(ca) * U1_W'(tqs);
    m2     = M2_W'(u1) * M2_W'(tqs);
    m3     = M2_W'(u2) * M2_W'(tqs);
    rsum   = u3 + (U3_W'(1) <<< 31);
    rshift = 32'(rsum >>> 32);
    if (rshift > 32'sd524287) begin
      sat = OUT_W'(524287);
    end else if (rshift < -32'sd524288) begin
      sat = OUT_W'(-524288);
    end else begin
      sat = OUT_W'(rshift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_QUERY) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx == last_idx) begin
          state_next = (scan_bad || !scan_found) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt == 5'(DIV_STEPS - 1)) begin
          state_next = ST_COEF;
        end
      end
      ST_COEF: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          q      <= query_time;
          rd_idx <= '0;
          bad    <= 1'b0;
          found  <= 1'b0;
          if (mode == MODE_LOAD) begin
            curve_value <= '0;
            error_code  <= wr_en ? ERR_OK : ERR_BAD_INDEX;
          end
        end
      end
      ST_SCAN: begin
        prev   <= rd_q;
        rd_idx <= rd_idx + IDX_W'(1);
        bad    <= scan_bad;
        found  <= scan_found;
        if (!found && scan_found) begin
          lo <= prev;
          hi <= rd_q;
        end
        dcnt <= '0;
        quo  <= '0;
        if (scan_bad) begin
          res_err <= ERR_ORDER;
        end else begin
          res_err <= scan_found ? ERR_OK : ERR_RANGE;
        end
      end
      ST_DIV: begin
        rem  <= take ? TIME_W'(trial - {1'b0, seg_len}) : trial[TIME_W-1:0];
        quo  <= {quo[TQ_W-2:0], take};
        dcnt <= dcnt + 5'd1;
      end
      ST_COEF: begin
        cc <= COEF_W'(3) * dl;
        cb <= b_w;
        ca <= a_w;
        p0 <= lo.kvalue;
      end
      ST_MUL1: begin
        u1 <= m1 + (U1_W'(cb) <<< 16);
      end
      ST_MUL2: begin
        u2 <= U1_W'(m2 >>> 16) + (U1_W'(cc) <<< 16);
      end
      ST_MUL3: begin
        u3 <= U3_W'(m3) + (U3_W'(p0) <<< 32);
      end
      ST_FIN: begin
        if (out_free) begin
          curve_value <= (res_err == ERR_OK) ? sat : '0;
          error_code  <= res_err;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_seg_positive: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> hi.ktime > lo.ktime)
    else $error("segment chosen with non-increasing times");

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_COEF |-> quo <= TQ_W'(65536))
    else $error("local parameter beyond one");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_OK) |-> curve_value == '0)
    else $error("nonzero value reported with an error");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && rd_idx == last_idx && !scan_bad && scan_found) |=> state == ST_DIV)
    else $error("scan did not hand over to the divider");
`endif

endmodule
